[rtl/rgb_to_hsv_converter_assert.svh]
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// Assertion helpers for the converter. Both expect clk and rst_n in scope.

// The consequent must hold in the same cycle as the antecedent.
`define RHC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("converter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("converter assertion failed");

`endif

[rtl/rgbhsv_pkg.sv]
package rgbhsv_pkg;

  localparam int COMPONENT_BITS = 8;
  localparam int HUE_BITS       = 16;
  localparam int SAT_BITS       = 16;

  // Both quotients are resolved to the same number of fraction bits, one more
  // than the wider result needs for round half up.
  localparam int FRAC_BITS = ((HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS) + 1;
  localparam int QUOT_BITS = FRAC_BITS + 1;

  // Saturation divides by max, hue divides by six times delta.
  localparam int SAT_DW = COMPONENT_BITS;
  localparam int HUE_DW = COMPONENT_BITS + 3;

  typedef struct packed {
    logic [COMPONENT_BITS-1:0] red;
    logic [COMPONENT_BITS-1:0] green;
    logic [COMPONENT_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]       hue;
    logic                      hue_valid;
    logic [SAT_BITS-1:0]       saturation;
    logic [COMPONENT_BITS-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [SAT_DW-1:0]    rem;
    logic [SAT_DW-1:0]    dvsr;
    logic [QUOT_BITS-1:0] quot;
  } sat_lane_t;

  typedef struct packed {
    logic [HUE_DW-1:0]    rem;
    logic [HUE_DW-1:0]    dvsr;
    logic [QUOT_BITS-1:0] quot;
  } hue_lane_t;

  typedef struct packed {
    logic                      vld;
    sat_lane_t                 sat;
    hue_lane_t                 hue;
    logic                      hue_valid;
    logic                      black;
    logic [COMPONENT_BITS-1:0] brightness;
  } stage_t;

endpackage

[rtl/rgbhsv_front.sv]
module rgbhsv_front
  import rgbhsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   pix_vld,
  input  pixel_t pix,
  output stage_t st_out
);

  logic [COMPONENT_BITS-1:0] mx, mn, delta;
  logic [HUE_DW-1:0]         six, num;
  logic [HUE_DW-1:0]         r_w, g_w, b_w, d_w;
  stage_t                    st_nxt, st_r;

  always_comb begin
    mx = pix.red;
    mn = pix.red;
    if (pix.green > mx) mx = pix.green;
    if (pix.blue > mx) mx = pix.blue;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;
    delta = mx - mn;

    r_w = HUE_DW'(pix.red);
    g_w = HUE_DW'(pix.green);
    b_w = HUE_DW'(pix.blue);
    d_w = HUE_DW'(delta);
    six = (d_w << 2) + (d_w << 1);

    // Sector numerator in units of a sixth of a turn times delta, kept
    // in the range zero up to six times delta.
    if (pix.red == mx) begin
      if (pix.green >= pix.blue) begin
        num = g_w - b_w;
      end else begin
        num = six - (b_w - g_w);
      end
    end else if (pix.green == mx) begin
      num = ((d_w << 1) + b_w) - r_w;
    end else begin
      num = ((d_w << 2) + r_w) - g_w;
    end

    st_nxt            = '0;
    st_nxt.vld        = pix_vld;
    st_nxt.hue_valid  = (delta != '0);
    st_nxt.black      = (mx == '0);
    st_nxt.brightness = mx;

    // Integer quotient bit; delta never exceeds max and num stays below six times delta.
    st_nxt.sat.dvsr = mx;
    if (delta == mx) begin
      st_nxt.sat.rem  = '0;
      st_nxt.sat.quot = QUOT_BITS'(1);
    end else begin
      st_nxt.sat.rem  = delta;
      st_nxt.sat.quot = '0;
    end
    st_nxt.hue.dvsr = six;
    st_nxt.hue.rem  = num;
    st_nxt.hue.quot = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule

[rtl/rgbhsv_cell.sv]
module rgbhsv_cell
  import rgbhsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  stage_t st_in,
  output stage_t st_out
);

  logic [SAT_DW:0] sat_sh;
  logic [HUE_DW:0] hue_sh;
  logic            sat_ge, hue_ge;
  stage_t          st_nxt, st_r;

  // One restoring step for each quotient: double the remainder, subtract
  // the divisor when it fits, and shift the outcome in as the next bit.
  always_comb begin
    st_nxt = st_in;

    sat_sh = {st_in.sat.rem, 1'b0};
    sat_ge = (sat_sh >= {1'b0, st_in.sat.dvsr});
    if (sat_ge) begin
      st_nxt.sat.rem = SAT_DW'(sat_sh - {1'b0, st_in.sat.dvsr});
    end else begin
      st_nxt.sat.rem = sat_sh[SAT_DW-1:0];
    end
    st_nxt.sat.quot = {st_in.sat.quot[QUOT_BITS-2:0], sat_ge};

    hue_sh = {st_in.hue.rem, 1'b0};
    hue_ge = (hue_sh >= {1'b0, st_in.hue.dvsr});
    if (hue_ge) begin
      st_nxt.hue.rem = HUE_DW'(hue_sh - {1'b0, st_in.hue.dvsr});
    end else begin
      st_nxt.hue.rem = hue_sh[HUE_DW-1:0];
    end
    st_nxt.hue.quot = {st_in.hue.quot[QUOT_BITS-2:0], hue_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule

[rtl/rgb_to_hsv_converter.sv]
// RGB to HSV converter. One pixel is accepted every clock cycle while the
// output is not stalled. The accepting edge loads max, min, delta and the
// hue sector numerator into the front register, a chain of 17 divider cells
// then resolves one quotient bit per cycle for saturation and hue side by
// side, and a final register rounds and delivers the result.
// While a result waits with out_ready low the whole chain holds, so in_ready
// follows the output register.
`include "rgb_to_hsv_converter_assert.svh"

module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  pixel_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output hsv_t   out_data
);

  logic                  en;
  stage_t                chain [0:FRAC_BITS];
  stage_t                last;
  logic [SAT_BITS+1:0]   sat_sum;
  logic [HUE_BITS+1:0]   hue_sum;
  hsv_t                  res_nxt;
  hsv_t                  out_data_r;
  logic                  out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  rgbhsv_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .pix_vld(in_valid),
    .pix    (in_data),
    .st_out (chain[0])
  );

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .st_in (chain[i]),
      .st_out(chain[i+1])
    );
  end

  assign last = chain[FRAC_BITS];

  // Add one at the first unused quotient bit and drop it: round half up.
  always_comb begin
    sat_sum = last.sat.quot[QUOT_BITS-1 -: SAT_BITS+2] + (SAT_BITS+2)'(1);
    hue_sum = last.hue.quot[QUOT_BITS-1 -: HUE_BITS+2] + (HUE_BITS+2)'(1);

    res_nxt            = '0;
    res_nxt.brightness = last.brightness;
    res_nxt.hue_valid  = last.hue_valid;
    if (last.black) begin
      res_nxt.saturation = '0;
    end else if (sat_sum[SAT_BITS+1]) begin
      res_nxt.saturation = '1;
    end else begin
      res_nxt.saturation = sat_sum[SAT_BITS:1];
    end
    // A hue that rounds up to a full turn wraps to zero here.
    if (last.hue_valid) begin
      res_nxt.hue = hue_sum[HUE_BITS:1];
    end else begin
      res_nxt.hue = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.vld;
      out_data_r  <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RHC_ASSERT_NEXT(a_front_load, in_valid && in_ready, chain[0].vld)
  `RHC_ASSERT_IMP(a_gray_hue, out_valid && !out_data.hue_valid, out_data.hue == '0)
  `RHC_ASSERT_IMP(a_black_sat, out_valid && (out_data.brightness == '0), out_data.saturation == '0)
  `RHC_ASSERT_IMP(a_no_stall, !out_valid || out_ready, in_ready)

endmodule
